FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define BQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/bq_pkg.sv
package bq_pkg;

   localparam int COEF_BITS_DEF = 12;
   localparam int DIN_W = 12;
   localparam int DATA_W = 20;
   localparam int ACC_W = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = 3'd4;

   localparam int B0_RST = 423;
   localparam int B1_RST = 846;
   localparam int B2_RST = 423;
   localparam int A1_RST = -757;
   localparam int A2_RST = 401;

   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-(2 ** (DATA_W - 1)));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_A1,
      ST_A2,
      ST_B1,
      ST_B2,
      ST_B0,
      ST_OUT
   } bq_state_type;

   typedef enum logic [2:0] {
      OP_A1,
      OP_A2,
      OP_B1,
      OP_B2,
      OP_B0
   } bq_op_type;

   typedef struct packed {
      logic      capture;
      logic      mul_en;
      bq_op_type sel;
      logic      fb_init;
      logic      fb_acc;
      logic      w_load;
      logic      y_acc;
      logic      finish;
   } bq_cmd_type;

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      priority if (v > ACC_MAX) begin
         r = ACC_MAX[DATA_W-1:0];
      end else if (v < ACC_MIN) begin
         r = ACC_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/iir_biquad_direct_form_two.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_din   (12-bit signed sample)
// rsp       out        rsp_valid/rsp_stall  rsp_dout  (20-bit signed, saturated)
// csr       in         csr_write_en         csr_index, csr_wdata (coefficients)
//
// one request runs in steps: accept, five passes through the one shared
// multiplier (a1, a2, b1, b2, b0), then the output step
// the shared multiplier sets the rate; a new request is taken once the block is idle
// the finished sample sits in an output register, so a stalled rsp only holds the
// output step when a previous result is still waiting
// synchronous reset restores default coefficients and clears the delay line
module iir_biquad_direct_form_two import bq_pkg::*; #(
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DIN_W-1:0]     req_din,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_dout,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic signed [COEF_BITS-1:0] csr_wdata
);

   bq_cmd_type cmd;

   bq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bq_datapath #(
      .COEF_BITS (COEF_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_din      (req_din),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_dout     (rsp_dout)
   );

endmodule

FILE: rtl/bq_datapath.sv
module bq_datapath import bq_pkg::*; #(
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bq_cmd_type                  cmd,
   input  logic signed [DIN_W-1:0]     req_din,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic signed [COEF_BITS-1:0] csr_wdata,
   output logic signed [DATA_W-1:0]    rsp_dout
);

   localparam int PROD_W = DATA_W + COEF_BITS;
   localparam int SHIFT = COEF_BITS - 1;

   logic signed [COEF_BITS-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [DATA_W-1:0]    w1_ff, w2_ff, w_ff, w_in;
   logic signed [DIN_W-1:0]     din_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in, shifted;
   logic signed [ACC_W-1:0]     fb_ff, y_ff, term;
   logic signed [DATA_W-1:0]    dout_ff, dout_in;
   logic signed [DATA_W-1:0]    op_d;
   logic signed [COEF_BITS-1:0] op_c;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_BITS'(B0_RST);
         b1_ff <= COEF_BITS'(B1_RST);
         b2_ff <= COEF_BITS'(B2_RST);
         a1_ff <= COEF_BITS'(A1_RST);
         a2_ff <= COEF_BITS'(A2_RST);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_B0: b0_ff <= csr_wdata;
            CSR_B1: b1_ff <= csr_wdata;
            CSR_B2: b2_ff <= csr_wdata;
            CSR_A1: a1_ff <= csr_wdata;
            CSR_A2: a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.sel)
         OP_A1: begin
            op_d = w1_ff;
            op_c = a1_ff;
         end
         OP_A2: begin
            op_d = w2_ff;
            op_c = a2_ff;
         end
         OP_B1: begin
            op_d = w1_ff;
            op_c = b1_ff;
         end
         OP_B2: begin
            op_d = w2_ff;
            op_c = b2_ff;
         end
         OP_B0: begin
            op_d = w_ff;
            op_c = b0_ff;
         end
         default: begin
            op_d = w_ff;
            op_c = b0_ff;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_d) * PROD_W'(op_c);
   // floor shift, result always fits the low ACC_W bits
   assign shifted = prod_ff >>> SHIFT;
   assign term = $signed(shifted[ACC_W-1:0]);
   assign w_in = sat_data(ACC_W'(din_ff) + ACC_W'(sat_data(fb_ff)));
   assign dout_in = sat_data(y_ff + term);

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_ff <= '0;
         w2_ff <= '0;
      end else if (cmd.finish) begin
         w2_ff <= w1_ff;
         w1_ff <= w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         din_ff <= req_din;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.fb_init) begin
         fb_ff <= -term;
      end else if (cmd.fb_acc) begin
         fb_ff <= fb_ff - term;
      end
      if (cmd.w_load) begin
         w_ff <= w_in;
         y_ff <= term;
      end else if (cmd.y_acc) begin
         y_ff <= y_ff + term;
      end
      if (cmd.finish) begin
         dout_ff <= dout_in;
      end
   end

   assign rsp_dout = dout_ff;

endmodule

FILE: rtl/bq_ctrl.sv
`include "assert_macros.svh"

module bq_ctrl import bq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output bq_cmd_type cmd
);

   bq_state_type state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.sel = OP_A1;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_A1;
            end
         end
         ST_A1: begin
            cmd.mul_en = 1'b1;
            cmd.sel = OP_A1;
            state_in = ST_A2;
         end
         ST_A2: begin
            cmd.mul_en = 1'b1;
            cmd.sel = OP_A2;
            cmd.fb_init = 1'b1;
            state_in = ST_B1;
         end
         ST_B1: begin
            cmd.mul_en = 1'b1;
            cmd.sel = OP_B1;
            cmd.fb_acc = 1'b1;
            state_in = ST_B2;
         end
         ST_B2: begin
            cmd.mul_en = 1'b1;
            cmd.sel = OP_B2;
            cmd.w_load = 1'b1;
            state_in = ST_B0;
         end
         ST_B0: begin
            cmd.mul_en = 1'b1;
            cmd.sel = OP_B0;
            cmd.y_acc = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BQ_ASSERT(a_accept_starts, clock, reset, (req_valid && !req_stall) |=> (state_ff == ST_A1), "accepted request did not start the sequence")
   `BQ_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT), "response raised outside the output step")
   `BQ_ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.finish && rsp_valid_ff && rsp_stall, "stalled response overwritten")

endmodule
